/* rtl/rc4_pkg.sv */
`default_nettype none

package rc4_pkg;

   localparam int unsigned MAX_KEY_BYTES_DEF = 16;
   localparam int unsigned KEY_IDX_W         = 4;
   localparam int unsigned STEP_W            = 4;

   localparam logic [1:0] FUNC_REKEY = 2'd0;
   localparam logic [1:0] FUNC_CRYPT = 2'd1;
   localparam logic [1:0] FUNC_SKIP  = 2'd2;

   typedef enum logic [STEP_W-1:0] {
      STEP_IDLE,
      STEP_FILL,
      STEP_KSA_A,
      STEP_KSA_B,
      STEP_KSA_C,
      STEP_KSA_D,
      STEP_KSA_E,
      STEP_KS_B,
      STEP_KS_C,
      STEP_KS_D
   } step_type;

   typedef enum logic [2:0] {
      RD_I_NEXT,
      RD_I,
      RD_J_IN,
      RD_SUM_RD,
      RD_SUM_REG
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_FILL,
      WR_J_SI,
      WR_I_SJ
   } wr_sel_type;

   typedef enum logic [1:0] {
      I_HOLD,
      I_INC,
      I_INC_KS,
      I_CLR
   } i_op_type;

   typedef enum logic [1:0] {
      J_HOLD,
      J_ADD,
      J_ADD_KEY,
      J_CLR
   } j_op_type;

   typedef enum logic [1:0] {
      K_HOLD,
      K_INC,
      K_CLR
   } k_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_I_NOT_LAST,
      JMP_DISPATCH
   } jmp_type;

   typedef struct packed {
      logic       take;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      i_op_type   i_op;
      j_op_type   j_op;
      k_op_type   k_op;
      logic       ld_si;
      logic       ld_sj;
      logic       emit;
      jmp_type    jmp;
      step_type   target;
   } ctrl_type;

   typedef struct packed {
      logic       accept;
      logic [1:0] func;
      logic       i_last;
      logic       stall;
   } seq_stat_type;

   localparam ctrl_type CTRL_NOP = '{
      take:   1'b0,
      rd_sel: RD_I,
      wr_sel: WR_NONE,
      i_op:   I_HOLD,
      j_op:   J_HOLD,
      k_op:   K_HOLD,
      ld_si:  1'b0,
      ld_sj:  1'b0,
      emit:   1'b0,
      jmp:    JMP_NEXT,
      target: STEP_IDLE
   };

   // microcode store
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type cw;
      cw = CTRL_NOP;
      unique case (step)
         STEP_IDLE: begin
            cw.take   = 1'b1;
            cw.rd_sel = RD_I_NEXT;
            cw.i_op   = I_INC_KS;
            cw.jmp    = JMP_DISPATCH;
         end
         STEP_FILL: begin
            cw.wr_sel = WR_FILL;
            cw.i_op   = I_INC;
            cw.j_op   = J_CLR;
            cw.k_op   = K_CLR;
            cw.jmp    = JMP_I_NOT_LAST;
            cw.target = STEP_FILL;
         end
         STEP_KSA_A: begin
            cw.rd_sel = RD_I;
         end
         STEP_KSA_B: begin
            cw.ld_si  = 1'b1;
            cw.j_op   = J_ADD_KEY;
            cw.rd_sel = RD_J_IN;
         end
         STEP_KSA_C: begin
            cw.ld_sj  = 1'b1;
            cw.wr_sel = WR_J_SI;
         end
         STEP_KSA_D: begin
            cw.wr_sel = WR_I_SJ;
            cw.i_op   = I_INC;
            cw.k_op   = K_INC;
            cw.jmp    = JMP_I_NOT_LAST;
            cw.target = STEP_KSA_A;
         end
         STEP_KSA_E: begin
            cw.i_op   = I_CLR;
            cw.j_op   = J_CLR;
            cw.k_op   = K_CLR;
            cw.jmp    = JMP_ALWAYS;
            cw.target = STEP_IDLE;
         end
         STEP_KS_B: begin
            cw.ld_si  = 1'b1;
            cw.j_op   = J_ADD;
            cw.rd_sel = RD_J_IN;
         end
         STEP_KS_C: begin
            cw.ld_sj  = 1'b1;
            cw.rd_sel = RD_SUM_RD;
            cw.wr_sel = WR_J_SI;
         end
         STEP_KS_D: begin
            cw.wr_sel = WR_I_SJ;
            cw.rd_sel = RD_SUM_REG;
            cw.emit   = 1'b1;
            cw.jmp    = JMP_ALWAYS;
            cw.target = STEP_IDLE;
         end
         default: begin
            cw.jmp    = JMP_ALWAYS;
            cw.target = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

/* rtl/rc4_seq.sv */
`default_nettype none

module rc4_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rc4_pkg::seq_stat_type stat,
   output rc4_pkg::ctrl_type          ctrl,
   output rc4_pkg::step_type          step
);

   rc4_pkg::step_type step_ff;
   rc4_pkg::step_type step_in;

   assign step = step_ff;
   assign ctrl = rc4_pkg::ucode(step_ff);

   always_comb begin
      step_in = rc4_pkg::step_type'(step_ff + rc4_pkg::STEP_W'(1));
      if (stat.stall) begin
         step_in = step_ff;
      end else begin
         unique case (ctrl.jmp)
            rc4_pkg::JMP_NEXT: begin
               step_in = rc4_pkg::step_type'(step_ff + rc4_pkg::STEP_W'(1));
            end
            rc4_pkg::JMP_ALWAYS: begin
               step_in = ctrl.target;
            end
            rc4_pkg::JMP_I_NOT_LAST: begin
               if (!stat.i_last) begin
                  step_in = ctrl.target;
               end
            end
            rc4_pkg::JMP_DISPATCH: begin
               step_in = step_ff;
               if (stat.accept) begin
                  priority if (stat.func == rc4_pkg::FUNC_REKEY) begin
                     step_in = rc4_pkg::STEP_FILL;
                  end else if (stat.func == rc4_pkg::FUNC_CRYPT ||
                               stat.func == rc4_pkg::FUNC_SKIP) begin
                     step_in = rc4_pkg::STEP_KS_B;
                  end else begin
                     step_in = step_ff;
                  end
               end
            end
            default: begin
               step_in = rc4_pkg::STEP_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rc4_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/rc4_stream_cipher_top.sv */
// Channel   Direction  Signals
// req_      in         req_valid/req_ready, req_func, req_data_in, req_last_in
// rsp_      out        rsp_valid/rsp_ready, rsp_data_out, rsp_last_out
// csr_      in/out     APB: psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Crypt and skip each make 3 permutation reads and 2 swap writes
// through the one read and one write port of the permutation RAM.
// Rekey makes 256 identity fill writes, then one mixing step (KSA_A to KSA_D) per entry.
// The crypt result lands in the output register in step KS_D; a new
// transaction is taken while it waits, and only the next crypt waits for it.
// Reset is synchronous; the permutation holds no defined value until rekey.
`default_nettype none

module rc4_stream_cipher_top #(
   parameter int unsigned MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_data_in,
   input  wire logic        req_last_in,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_data_out,
   output      logic        rsp_last_out,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output      logic [63:0] prdata,
   output      logic        pready
);

   localparam logic [1:0] CSR_KEY_LOW    = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH   = 2'd1;
   localparam logic [1:0] CSR_KEY_LENGTH = 2'd2;
   localparam logic [4:0] MAX_LEN        = 5'(MAX_KEY_BYTES);

   rc4_pkg::ctrl_type     ctrl;
   rc4_pkg::seq_stat_type stat;
   rc4_pkg::step_type     step;

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [4:0]  key_length_ff;
   logic        csr_wr;

   logic [7:0] perm_mem [256];
   logic [7:0] mem_rdata_ff;
   logic [7:0] mem_raddr;
   logic [7:0] mem_waddr;
   logic [7:0] mem_wdata;
   logic       mem_we;

   logic [7:0]                    i_ff, i_in;
   logic [7:0]                    j_ff, j_in;
   logic [rc4_pkg::KEY_IDX_W-1:0] key_idx_ff, key_idx_in;
   logic [7:0]                    si_ff, sj_ff;
   logic [1:0]                    func_ff;
   logic [7:0]                    data_ff;
   logic                          last_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;

   logic         accept;
   logic         is_ks;
   logic         stall;
   logic         rsp_load;
   logic [4:0]   len_eff;
   logic         key_wrap;
   logic [127:0] key_bytes;
   logic [7:0]   key_byte;
   logic [7:0]   sum_reg;
   logic [7:0]   ks_byte;

   // configuration
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= 5'd16;
      end else if (csr_wr) begin
         unique case (paddr[4:3])
            CSR_KEY_LOW:    key_low_ff    <= pwdata;
            CSR_KEY_HIGH:   key_high_ff   <= pwdata;
            CSR_KEY_LENGTH: key_length_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         CSR_KEY_LOW:    prdata = key_low_ff;
         CSR_KEY_HIGH:   prdata = key_high_ff;
         CSR_KEY_LENGTH: prdata = {59'd0, key_length_ff};
         default:        prdata = '0;
      endcase
   end

   always_comb begin
      if (key_length_ff == 5'd0) begin
         len_eff = 5'd1;
      end else if (key_length_ff > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = key_length_ff;
      end
   end

   assign key_bytes = {key_high_ff, key_low_ff};
   assign key_byte  = key_bytes[{key_idx_ff, 3'b000} +: 8];
   assign key_wrap  = ({1'b0, key_idx_ff} == (len_eff - 5'd1));

   // sequencer
   assign req_ready = ctrl.take;
   assign accept    = req_valid && ctrl.take;
   assign is_ks     = (req_func == rc4_pkg::FUNC_CRYPT) || (req_func == rc4_pkg::FUNC_SKIP);
   assign stall     = ctrl.emit && (func_ff == rc4_pkg::FUNC_CRYPT) && rsp_valid_ff && !rsp_ready;
   assign rsp_load  = ctrl.emit && (func_ff == rc4_pkg::FUNC_CRYPT) && !stall;

   assign stat.accept = accept;
   assign stat.func   = req_func;
   assign stat.i_last = (i_ff == 8'hFF);
   assign stat.stall  = stall;

   rc4_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl),
      .step  (step)
   );

   // datapath
   always_comb begin
      unique case (ctrl.j_op)
         rc4_pkg::J_ADD:     j_in = j_ff + mem_rdata_ff;
         rc4_pkg::J_ADD_KEY: j_in = j_ff + mem_rdata_ff + key_byte;
         rc4_pkg::J_CLR:     j_in = 8'd0;
         default:            j_in = j_ff;
      endcase
   end

   always_comb begin
      unique case (ctrl.i_op)
         rc4_pkg::I_INC:    i_in = i_ff + 8'd1;
         rc4_pkg::I_INC_KS: i_in = !accept ? i_ff : is_ks ? i_ff + 8'd1 :
                                   (req_func == rc4_pkg::FUNC_REKEY) ? 8'd0 : i_ff;
         rc4_pkg::I_CLR:    i_in = 8'd0;
         default:           i_in = i_ff;
      endcase
   end

   always_comb begin
      unique case (ctrl.k_op)
         rc4_pkg::K_INC: key_idx_in = key_wrap ? '0 : key_idx_ff + 1'b1;
         rc4_pkg::K_CLR: key_idx_in = '0;
         default:        key_idx_in = key_idx_ff;
      endcase
   end

   assign sum_reg = si_ff + sj_ff;

   always_comb begin
      unique case (ctrl.rd_sel)
         rc4_pkg::RD_I_NEXT:  mem_raddr = i_ff + 8'd1;
         rc4_pkg::RD_I:       mem_raddr = i_ff;
         rc4_pkg::RD_J_IN:    mem_raddr = j_in;
         rc4_pkg::RD_SUM_RD:  mem_raddr = si_ff + mem_rdata_ff;
         rc4_pkg::RD_SUM_REG: mem_raddr = sum_reg;
         default:             mem_raddr = i_ff;
      endcase
   end

   always_comb begin
      mem_we    = 1'b1;
      mem_waddr = i_ff;
      mem_wdata = i_ff;
      unique case (ctrl.wr_sel)
         rc4_pkg::WR_FILL: begin
            mem_waddr = i_ff;
            mem_wdata = i_ff;
         end
         rc4_pkg::WR_J_SI: begin
            mem_waddr = j_ff;
            mem_wdata = si_ff;
         end
         rc4_pkg::WR_I_SJ: begin
            mem_waddr = i_ff;
            mem_wdata = sj_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= perm_mem[mem_raddr];
   end

   // sum read overlaps the swap, so patch in the swapped values
   always_comb begin
      priority if (sum_reg == i_ff) begin
         ks_byte = sj_ff;
      end else if (sum_reg == j_ff) begin
         ks_byte = si_ff;
      end else begin
         ks_byte = mem_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff       <= '0;
         j_ff       <= '0;
         key_idx_ff <= '0;
      end else begin
         i_ff       <= i_in;
         j_ff       <= j_in;
         key_idx_ff <= key_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_si) begin
         si_ff <= mem_rdata_ff;
      end
      if (ctrl.ld_sj) begin
         sj_ff <= mem_rdata_ff;
      end
      if (accept) begin
         func_ff <= req_func;
         data_ff <= req_data_in;
         last_ff <= req_last_in;
      end
   end

   // output register
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= data_ff ^ ks_byte;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_last_out = rsp_last_ff;

`ifndef SYNTHESIS
   a_crypt_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == rc4_pkg::FUNC_CRYPT) |-> ##4 rsp_valid)
      else $error("crypt transaction produced no result");

   a_ksa_end: assert property (@(posedge clock) disable iff (reset)
      (step == rc4_pkg::STEP_KSA_E) |-> (i_ff == 8'd0))
      else $error("key schedule ended with nonzero i");

   a_key_idx: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, key_idx_ff} < len_eff) || (step == rc4_pkg::STEP_IDLE))
      else $error("key index beyond key length");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_rc4_stream_cipher_top.sv */
`default_nettype none

module tb_rc4_stream_cipher_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_IGNORED    = 2'd3;
   localparam logic [4:0] ADDR_KEY_LOW    = 5'd0;
   localparam logic [4:0] ADDR_KEY_HIGH   = 5'd8;
   localparam logic [4:0] ADDR_KEY_LENGTH = 5'd16;
   localparam int         REKEY_TAIL      = 1400;
   localparam int         PHASE_ITEMS     = 94;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data;
      logic       last;
   } cipher_req_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } cipher_rsp_type;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func     = rc4_pkg::FUNC_REKEY;
   logic [7:0]  req_data_in  = 8'd0;
   logic        req_last_in  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic [7:0]  rsp_data_out;
   logic        rsp_last_out;
   logic        psel         = 1'b0;
   logic        penable      = 1'b0;
   logic        pwrite       = 1'b0;
   logic [4:0]  paddr        = 5'd0;
   logic [63:0] pwdata       = 64'd0;
   logic [63:0] prdata;
   logic        pready;

   int          idle_pct     = 0;
   int          stall_pct    = 0;
   logic        rsp_hold     = 1'b0;
   int          mismatches   = 0;

   cipher_req_type pending_items[$];
   cipher_rsp_type expected_bytes[$];
   cipher_req_type cur_item;

   // cipher state mirror
   logic [7:0]  perm [256];
   logic [7:0]  idx_i = 8'd0;
   logic [7:0]  idx_j = 8'd0;
   logic [63:0] key_lo = 64'd0;
   logic [63:0] key_hi = 64'd0;
   logic [4:0]  key_len = 5'd16;

   rc4_stream_cipher_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_data_in  (req_data_in),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out),
      .rsp_last_out (rsp_last_out),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] key_byte_at(input int k);
      if (k < 8) begin
         return key_lo[8*k +: 8];
      end
      return key_hi[8*(k-8) +: 8];
   endfunction

   function automatic void schedule_key();
      int         len;
      logic [7:0] j;
      logic [7:0] t;
      len = key_len;
      if (len < 1) begin
         len = 1;
      end
      if (len > rc4_pkg::MAX_KEY_BYTES_DEF) begin
         len = rc4_pkg::MAX_KEY_BYTES_DEF;
      end
      for (int n = 0; n < 256; n++) begin
         perm[n] = n[7:0];
      end
      j = 8'd0;
      for (int n = 0; n < 256; n++) begin
         j       = j + perm[n] + key_byte_at(n % len);
         t       = perm[n];
         perm[n] = perm[j];
         perm[j] = t;
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
   endfunction

   function automatic logic [7:0] keystream_byte();
      logic [7:0] t;
      logic [7:0] s;
      idx_i       = idx_i + 8'd1;
      idx_j       = idx_j + perm[idx_i];
      t           = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = t;
      s           = perm[idx_i] + perm[idx_j];
      return perm[s];
   endfunction

   function automatic void predict_transaction(input cipher_req_type r);
      logic [7:0]     ks;
      cipher_rsp_type e;
      case (r.func)
         rc4_pkg::FUNC_REKEY: begin
            schedule_key();
         end
         rc4_pkg::FUNC_SKIP: begin
            ks = keystream_byte();
         end
         rc4_pkg::FUNC_CRYPT: begin
            ks     = keystream_byte();
            e.data = r.data ^ ks;
            e.last = r.last;
            expected_bytes.push_back(e);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 50) begin
         $display("%0t mismatch: %s", $time, what);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_transaction(cur_item);
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
               cur_item = pending_items.pop_front();
               req_valid   <= 1'b1;
               req_func    <= cur_item.func;
               req_data_in <= cur_item.data;
               req_last_in <= cur_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      cipher_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction data %h last %b",
                                         rsp_data_out, rsp_last_out));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data_out !== want.data) begin
                  report_mismatch($sformatf("data_out %h, want %h", rsp_data_out, want.data));
               end
               if (rsp_last_out !== want.last) begin
                  report_mismatch($sformatf("last_out %b, want %b", rsp_last_out, want.last));
               end
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_key_reg(input logic [4:0] addr, input logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (addr)
         ADDR_KEY_LOW:    key_lo  = value;
         ADDR_KEY_HIGH:   key_hi  = value;
         ADDR_KEY_LENGTH: key_len = value[4:0];
         default: begin
         end
      endcase
   endtask

   task automatic settle(input int tail);
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (tail) @(negedge clock);
   endtask

   task automatic hold_receiver(input int span);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (span) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   function automatic cipher_req_type make_item(input logic [1:0] func,
                                                input logic [7:0] data,
                                                input logic last);
      cipher_req_type r;
      r.func = func;
      r.data = data;
      r.last = last;
      return r;
   endfunction

   function automatic cipher_req_type random_item();
      int         pick;
      logic [1:0] func;
      pick = $urandom_range(99);
      if (pick < 3) begin
         func = rc4_pkg::FUNC_REKEY;
      end else if (pick < 17) begin
         func = rc4_pkg::FUNC_SKIP;
      end else if (pick < 21) begin
         func = FUNC_IGNORED;
      end else begin
         func = rc4_pkg::FUNC_CRYPT;
      end
      return make_item(func, 8'($urandom), $urandom_range(7) == 0);
   endfunction

   task automatic queue_random(input int count);
      cipher_req_type r;
      int             n;
      n = 0;
      while (n < count) begin
         r = random_item();
         pending_items.push_back(r);
         if (r.func != FUNC_IGNORED) begin
            n++;
         end
      end
   endtask

   task automatic run_phase(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input int idle, input int stall,
                            input bit long_hold);
      settle(REKEY_TAIL);
      write_key_reg(ADDR_KEY_LOW, lo);
      write_key_reg(ADDR_KEY_HIGH, hi);
      write_key_reg(ADDR_KEY_LENGTH, {59'd0, len});
      idle_pct  <= idle;
      stall_pct <= stall;
      @(negedge clock);
      if (long_hold) begin
         fork
            hold_receiver(3000);
         join_none
      end
      pending_items.push_back(make_item(rc4_pkg::FUNC_REKEY, 8'd0, 1'b0));
      queue_random(PHASE_ITEMS / 2);
      // sender waits for every outstanding byte mid-stream
      settle(0);
      queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
   endtask

   initial begin
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset key: all zero bytes, length 16
      pending_items.push_back(make_item(rc4_pkg::FUNC_REKEY, 8'h00, 1'b0));
      pending_items.push_back(make_item(rc4_pkg::FUNC_CRYPT, 8'h00, 1'b0));
      pending_items.push_back(make_item(rc4_pkg::FUNC_CRYPT, 8'hFF, 1'b1));
      pending_items.push_back(make_item(rc4_pkg::FUNC_CRYPT, 8'h80, 1'b0));
      pending_items.push_back(make_item(rc4_pkg::FUNC_CRYPT, 8'h01, 1'b0));
      pending_items.push_back(make_item(rc4_pkg::FUNC_SKIP,  8'hFF, 1'b1));
      pending_items.push_back(make_item(rc4_pkg::FUNC_SKIP,  8'h00, 1'b0));
      pending_items.push_back(make_item(FUNC_IGNORED,        8'hFF, 1'b1));
      pending_items.push_back(make_item(rc4_pkg::FUNC_CRYPT, 8'h55, 1'b0));
      pending_items.push_back(make_item(rc4_pkg::FUNC_CRYPT, 8'hAA, 1'b1));
      pending_items.push_back(make_item(rc4_pkg::FUNC_REKEY, 8'hFF, 1'b1));
      pending_items.push_back(make_item(FUNC_IGNORED,        8'h00, 1'b0));
      pending_items.push_back(make_item(rc4_pkg::FUNC_CRYPT, 8'h00, 1'b0));
      pending_items.push_back(make_item(rc4_pkg::FUNC_SKIP,  8'h5A, 1'b0));
      pending_items.push_back(make_item(rc4_pkg::FUNC_CRYPT, 8'hFF, 1'b1));

      for (int p = 0; p < 12; p++) begin
         case (p)
            0:       len = 5'd16;
            1:       len = 5'd1;
            2:       len = 5'd0;
            3:       len = 5'd31;
            4:       len = 5'd17;
            default: len = 5'($urandom_range(1, 16));
         endcase
         if (p == 1) begin
            lo = '1;
            hi = '1;
         end else if (p == 4) begin
            lo = '0;
            hi = '0;
         end else begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
         end
         case (p % 4)
            0:       run_phase(lo, hi, len, 0, 0, p == 4);
            1:       run_phase(lo, hi, len, 59, 0, 1'b0);
            2:       run_phase(lo, hi, len, 0, 59, 1'b0);
            default: run_phase(lo, hi, len, 12, 12, 1'b0);
         endcase
      end

      settle(REKEY_TAIL);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

/* rc4_stream_cipher_top.f */
rtl/rc4_pkg.sv
rtl/rc4_seq.sv
rtl/rc4_stream_cipher_top.sv
tb/sv/tb_rc4_stream_cipher_top.sv
